// ===== rtl/vzw_pkg.sv =====
// ----------------------------------------------------------------------------
// vzw_pkg
// Shared types and constants of the varint / zigzag buffer writer.
// ----------------------------------------------------------------------------
package vzw_pkg;

    localparam int CAP_W    = 17;
    localparam int POS_W    = 16;
    localparam int LEN_W    = 4;
    localparam int CMD_W    = 4;
    localparam int VAL_W    = 64;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;
    localparam int Q_CNT_W  = 3;

    localparam logic [CAP_W-1:0] MAX_BUFFER_BYTES = 17'd65536;
    localparam logic [CAP_W-1:0] CAP_RESET        = 17'd65536;

    localparam logic [CMD_W-1:0] CMD_BYTE    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_DOUBLE  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_U16     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_S16     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_U32     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_S32     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_U64     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_S64     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_STR     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_RESTART = 4'd9;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOS = 1'b1;

    // one classified request as handed from front to back
    typedef struct packed {
        logic             no_byte;  // single result without a written byte
        logic             raw;      // bytes taken 8 bits at a time, no continuation bit
        logic             status;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] data;
    } t_entry;

endpackage

// ===== rtl/vzw_front.sv =====
// ----------------------------------------------------------------------------
// vzw_front
// Accepts requests, encodes the value, sizes the item, checks free space
// and keeps the write offset and the capacity register.
// ----------------------------------------------------------------------------
module vzw_front
    import vzw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_command,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_cfg_valid,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    logic [CAP_W-1:0] r_capacity;
    logic [CAP_W-1:0] r_offset;
    logic [CAP_W-1:0] n_offset;

    logic [VAL_W-1:0] enc;
    logic [LEN_W-1:0] leb_len;
    logic [LEN_W-1:0] len;
    logic             writes;
    logic             raw;
    logic             restart;
    logic [CAP_W-1:0] cap_eff;
    logic [CAP_W:0]   end_pos;
    logic             fits;

    assign o_push = i_valid && !i_q_full;

    always_comb begin
        enc     = i_value;
        raw     = 1'b0;
        writes  = 1'b1;
        restart = 1'b0;
        case (i_command)
            CMD_BYTE, CMD_STR: begin
                enc = {56'd0, i_value[7:0]};
                raw = 1'b1;
            end
            CMD_DOUBLE: begin
                raw = 1'b1;
            end
            CMD_U16: enc = {48'd0, i_value[15:0]};
            CMD_S16: enc = {48'd0, {i_value[14:0], 1'b0} ^ {16{i_value[15]}}};
            CMD_U32: enc = {32'd0, i_value[31:0]};
            CMD_S32: enc = {32'd0, {i_value[30:0], 1'b0} ^ {32{i_value[31]}}};
            CMD_U64: enc = i_value;
            CMD_S64: enc = {i_value[62:0], 1'b0} ^ {64{i_value[63]}};
            CMD_RESTART: begin
                writes  = 1'b0;
                restart = 1'b1;
            end
            default: writes = 1'b0;
        endcase
    end

    // varint length: set by the highest non-empty 7-bit group
    always_comb begin
        leb_len = LEN_W'(1);
        for (int k = 1; k < 10; k++) begin
            if ((enc >> (7 * k)) != '0) begin
                leb_len = LEN_W'(k + 1);
            end
        end
    end

    always_comb begin
        if (!raw) begin
            len = leb_len;
        end else if (i_command == CMD_DOUBLE) begin
            len = LEN_W'(8);
        end else begin
            len = LEN_W'(1);
        end
    end

    assign cap_eff = (r_capacity > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES : r_capacity;
    // offset beyond capacity also fails here since len is at least one
    assign end_pos = {1'b0, r_offset} + {{(CAP_W + 1 - LEN_W){1'b0}}, len};
    assign fits    = end_pos <= {1'b0, cap_eff};

    always_comb begin
        o_entry.data    = enc;
        o_entry.raw     = raw;
        o_entry.len     = len;
        o_entry.pos     = r_offset[POS_W-1:0];
        o_entry.no_byte = !(writes && fits);
        o_entry.status  = (writes && !fits) ? STATUS_OOS : STATUS_OK;
    end

    always_comb begin
        n_offset = r_offset;
        if (o_push) begin
            if (restart) begin
                n_offset = '0;
            end else if (writes && fits) begin
                n_offset = end_pos[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_capacity <= CAP_RESET;
        end else begin
            r_offset <= n_offset;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

endmodule

// ===== rtl/vzw_queue.sv =====
// ----------------------------------------------------------------------------
// vzw_queue
// Small request queue between the front and the back.
// ----------------------------------------------------------------------------
module vzw_queue
    import vzw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry               r_store [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_CNT_W-1:0]   n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = r_count == Q_CNT_W'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_store[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
        end
    end

endmodule

// ===== rtl/vzw_back.sv =====
// ----------------------------------------------------------------------------
// vzw_back
// Takes queued requests and emits their bytes one per cycle through an
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module vzw_back
    import vzw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_entry           i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_byte,
    output logic [POS_W-1:0] o_byte_position,
    output logic             o_byte_valid,
    output logic             o_last_of_item,
    output logic             o_status
);

    logic             r_act;
    logic [VAL_W-1:0] r_shift;
    logic [LEN_W-1:0] r_left;
    logic [POS_W-1:0] r_pos;
    logic             r_raw;
    logic             r_no_byte;
    logic             r_stat;

    logic             r_ov;
    logic [7:0]       r_ob;
    logic [POS_W-1:0] r_opos;
    logic             r_obv;
    logic             r_olast;
    logic             r_ostat;

    logic             out_free;
    logic             emit;
    logic             is_last;
    logic [7:0]       cur_byte;

    assign out_free = !r_ov || !i_stall;
    assign emit     = r_act && out_free;
    assign is_last  = r_left == LEN_W'(1);
    // next request loads as the last byte of the current one leaves
    assign o_pop    = !i_q_empty && (!r_act || (emit && is_last));

    always_comb begin
        if (r_no_byte) begin
            cur_byte = '0;
        end else if (r_raw) begin
            cur_byte = r_shift[7:0];
        end else begin
            cur_byte = {!is_last, r_shift[6:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (emit && is_last) begin
                r_act <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift   <= i_head.data;
            r_left    <= i_head.no_byte ? LEN_W'(1) : i_head.len;
            r_pos     <= i_head.pos;
            r_raw     <= i_head.raw;
            r_no_byte <= i_head.no_byte;
            r_stat    <= i_head.status;
        end else if (emit) begin
            r_shift <= r_raw ? (r_shift >> 8) : (r_shift >> 7);
            r_left  <= r_left - LEN_W'(1);
            r_pos   <= r_pos + POS_W'(1);
        end
        if (emit) begin
            r_ob    <= cur_byte;
            r_opos  <= r_no_byte ? '0 : r_pos;
            r_obv   <= !r_no_byte;
            r_olast <= is_last;
            r_ostat <= r_stat;
        end
    end

    assign o_valid         = r_ov;
    assign o_out_byte      = r_ob;
    assign o_byte_position = r_opos;
    assign o_byte_valid    = r_obv;
    assign o_last_of_item  = r_olast;
    assign o_status        = r_ostat;

endmodule

// ===== rtl/varint_zigzag_buffer_writer.sv =====
// ----------------------------------------------------------------------------
// varint_zigzag_buffer_writer
// Serialises typed values (raw bytes, doubles, zigzag/LEB128 varints) into a
// bounded byte buffer and emits each byte with its buffer position.
// ----------------------------------------------------------------------------
// A request is taken when the four-entry queue has room; the front encodes
// it, checks it against the free space and moves the write offset at once.
// The back then emits one result per cycle on the byte-wide output unless
// stalled, one to ten per request (one for a byte, string character, restart,
// ignored code or out-of-space report, eight for a double, the varint length
// otherwise), so sustained rate is set by the output channel. The user must
// write capacity via the config port only while idle; it is not enforced.
module varint_zigzag_buffer_writer
    import vzw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CMD_W-1:0] i_command,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_byte,
    output logic [POS_W-1:0] o_byte_position,
    output logic             o_byte_valid,
    output logic             o_last_of_item,
    output logic             o_status,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    t_entry push_entry;
    t_entry head;

    assign o_stall     = q_full;
    assign o_cfg_ready = 1'b1;

    vzw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    vzw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    vzw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_position (o_byte_position),
        .o_byte_valid    (o_byte_valid),
        .o_last_of_item  (o_last_of_item),
        .o_status        (o_status)
    );

endmodule
